// ===== rtl/first_fit_heap_allocator_defines.svh =====
// assertion macros used by the checker file
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FFHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the heap allocator controller and datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int unsigned HEAP_UNITS   = 65536;
    localparam int unsigned UNIT_W       = 16;
    localparam int unsigned TOP_W        = 17;
    localparam int unsigned SIZE_W       = 18;
    localparam int unsigned LIMIT_W      = 17;
    localparam int unsigned PTR_W        = 19;
    localparam int unsigned ADDR_W       = 19;
    localparam int unsigned REQ_W        = 20;
    localparam int unsigned STEPS_W      = 17;
    localparam int unsigned HEADER_UNITS = 3;
    localparam int unsigned INIT_UNITS   = 512;
    localparam int unsigned SPLIT_SPARE  = 2;

    // result status codes
    typedef enum logic [2:0] {
        ST_ALLOC = 3'd0,
        ST_ZERO  = 3'd1,
        ST_OOM   = 3'd2,
        ST_FREED = 3'd3,
        ST_NULL  = 3'd4
    } t_status;

    // one block header as held in the header memory
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [UNIT_W-1:0] next;
        logic              is_free;
        logic              next_valid;
    } t_hdr;

    // datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_RD_B,
        OP_INIT,
        OP_WALK_BEGIN,
        OP_RD_WALK,
        OP_ADVANCE,
        OP_GROW,
        OP_SPLIT,
        OP_LINK,
        OP_TAKE,
        OP_MARK,
        OP_RD_CUR,
        OP_CAPTURE,
        OP_RD_NXT,
        OP_MERGE,
        OP_SCAN_WR,
        OP_RET_ALLOC,
        OP_RET_ZERO,
        OP_RET_OOM,
        OP_RET_FREED,
        OP_RET_NULL
    } t_op;

    // datapath flags seen by the controller
    typedef struct packed {
        logic act;
        logic size_zero;
        logic addr_zero;
        logic ready;
        logic init_ok;
        logic walk_more;
        logic fit;
        logic split_ok;
        logic grow_ok;
        logic cur_ok;
        logic hdr_ok;
        logic hdr_free;
        logic nxt_ok;
        logic nxt_merge;
    } t_dp_stat;

endpackage

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate and free: walks the free list and the heap scan by
// issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_op     o_op,
    output logic              o_busy
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_AL_CHECK,
        S_AL_TEST,
        S_AL_LINK,
        S_AL_TAKE,
        S_RET_ALLOC,
        S_FR_MARK,
        S_SC_CHECK,
        S_SC_TEST,
        S_SC_MCHK,
        S_SC_MTEST,
        S_SC_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    n_op;

    // next state and operation
    always_comb begin
        n_state = r_state;
        n_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.act) begin
                    if (i_stat.addr_zero) begin
                        n_op    = OP_RET_NULL;
                        n_state = S_IDLE;
                    end else begin
                        n_op    = OP_RD_B;
                        n_state = S_FR_MARK;
                    end
                end else if (i_stat.size_zero) begin
                    n_op    = OP_RET_ZERO;
                    n_state = S_IDLE;
                end else if (!i_stat.ready && i_stat.init_ok) begin
                    // set up the initial block, then come back here
                    n_op = OP_INIT;
                end else if (!i_stat.ready) begin
                    n_op    = OP_RET_OOM;
                    n_state = S_IDLE;
                end else begin
                    n_op    = OP_WALK_BEGIN;
                    n_state = S_AL_CHECK;
                end
            end
            S_AL_CHECK: begin
                if (i_stat.walk_more) begin
                    n_op    = OP_RD_WALK;
                    n_state = S_AL_TEST;
                end else if (i_stat.grow_ok) begin
                    n_op    = OP_GROW;
                    n_state = S_RET_ALLOC;
                end else begin
                    n_op    = OP_RET_OOM;
                    n_state = S_IDLE;
                end
            end
            S_AL_TEST: begin
                if (i_stat.fit) begin
                    n_op    = i_stat.split_ok ? OP_SPLIT : OP_NOP;
                    n_state = S_AL_LINK;
                end else begin
                    n_op    = OP_ADVANCE;
                    n_state = S_AL_CHECK;
                end
            end
            S_AL_LINK: begin
                n_op    = OP_LINK;
                n_state = S_AL_TAKE;
            end
            S_AL_TAKE: begin
                n_op    = OP_TAKE;
                n_state = S_RET_ALLOC;
            end
            S_RET_ALLOC: begin
                n_op    = OP_RET_ALLOC;
                n_state = S_IDLE;
            end
            S_FR_MARK: begin
                n_op    = OP_MARK;
                n_state = S_SC_CHECK;
            end
            S_SC_CHECK: begin
                if (i_stat.cur_ok) begin
                    n_op    = OP_RD_CUR;
                    n_state = S_SC_TEST;
                end else begin
                    n_op    = OP_RET_FREED;
                    n_state = S_IDLE;
                end
            end
            S_SC_TEST: begin
                if (!i_stat.hdr_ok) begin
                    n_op    = OP_RET_FREED;
                    n_state = S_IDLE;
                end else begin
                    n_op    = OP_CAPTURE;
                    n_state = i_stat.hdr_free ? S_SC_MCHK : S_SC_WRITE;
                end
            end
            S_SC_MCHK: begin
                if (i_stat.nxt_ok) begin
                    n_op    = OP_RD_NXT;
                    n_state = S_SC_MTEST;
                end else begin
                    n_state = S_SC_WRITE;
                end
            end
            S_SC_MTEST: begin
                if (i_stat.nxt_merge) begin
                    n_op    = OP_MERGE;
                    n_state = S_SC_MCHK;
                end else begin
                    n_state = S_SC_WRITE;
                end
            end
            S_SC_WRITE: begin
                n_op    = OP_SCAN_WR;
                n_state = S_SC_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_op   = n_op;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Header memory, heap registers and result registers of the allocator.
// ----------------------------------------------------------------------------
module ffha_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffha_pkg::t_op               i_op,
    input  logic                        i_action,
    input  logic [ffha_pkg::REQ_W-1:0]  i_size_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0] i_address,
    input  logic                        i_cfg_wr,
    input  logic [ffha_pkg::LIMIT_W-1:0] i_limit,
    output ffha_pkg::t_dp_stat          o_stat,
    output logic [ffha_pkg::PTR_W-1:0]  o_pointer_offset,
    output logic [2:0]                  o_status,
    output logic                        o_done
);
    import ffha_pkg::*;

    t_hdr mem [HEAP_UNITS];

    // control state
    logic [TOP_W-1:0]   r_top;
    logic [UNIT_W-1:0]  r_fh;
    logic               r_fhv;
    logic               r_ready;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_done;

    // working registers
    t_hdr               r_rd;
    t_hdr               r_phdr;
    t_hdr               r_c;
    logic               r_act;
    logic               r_size_zero;
    logic               r_addr_zero;
    logic [UNIT_W-1:0]  r_addr_units;
    logic [SIZE_W-1:0]  r_need;
    logic [UNIT_W-1:0]  r_b;
    logic               r_bv;
    logic [UNIT_W-1:0]  r_prev;
    logic               r_pv;
    logic [STEPS_W-1:0] r_steps;
    logic [SIZE_W-1:0]  r_cur;
    logic [SIZE_W-1:0]  r_nxt;
    logic [PTR_W-1:0]   r_ptr;
    logic [2:0]         r_status;

    logic [REQ_W:0]     size_rnd;
    logic [SIZE_W-1:0]  need_in;
    logic [LIMIT_W-1:0] eff_lim;
    logic               split;
    logic [UNIT_W-1:0]  sp;
    logic [UNIT_W-1:0]  s_next;
    logic               s_nv;
    logic [UNIT_W-1:0]  free_unit;
    logic [SIZE_W-1:0]  merged;
    logic               rd_en;
    logic [UNIT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [UNIT_W-1:0]  wr_addr;
    t_hdr               wr_data;

    // derived values
    always_comb begin
        size_rnd  = {1'b0, i_size_bytes} + (REQ_W+1)'(7);
        need_in   = SIZE_W'(size_rnd[REQ_W:3]) + SIZE_W'(HEADER_UNITS);
        eff_lim   = (r_limit > LIMIT_W'(HEAP_UNITS)) ? LIMIT_W'(HEAP_UNITS) : r_limit;
        split     = ({1'b0, r_rd.size}) >=
                    ({1'b0, r_need} + (SIZE_W+1)'(HEADER_UNITS + SPLIT_SPARE));
        sp        = r_b + r_need[UNIT_W-1:0];
        s_next    = split ? sp : r_rd.next;
        s_nv      = split | r_rd.next_valid;
        free_unit = r_addr_units - UNIT_W'(HEADER_UNITS);
        merged    = r_c.size + r_rd.size;
    end

    // status flags to the controller
    always_comb begin
        o_stat.act       = r_act;
        o_stat.size_zero = r_size_zero;
        o_stat.addr_zero = r_addr_zero;
        o_stat.ready     = r_ready;
        o_stat.init_ok   = (LIMIT_W'(INIT_UNITS) <= eff_lim);
        o_stat.walk_more = r_bv && !r_steps[STEPS_W-1];
        o_stat.fit       = r_rd.is_free && (r_rd.size >= r_need);
        o_stat.split_ok  = split;
        o_stat.grow_ok   = ((SIZE_W+1)'(r_top) + (SIZE_W+1)'(r_need)) <= (SIZE_W+1)'(eff_lim);
        o_stat.cur_ok    = r_cur < SIZE_W'(r_top);
        o_stat.hdr_ok    = r_rd.size >= SIZE_W'(HEADER_UNITS);
        o_stat.hdr_free  = r_rd.is_free;
        o_stat.nxt_ok    = r_nxt < SIZE_W'(r_top);
        o_stat.nxt_merge = (r_rd.size >= SIZE_W'(HEADER_UNITS)) && r_rd.is_free;
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_b;
        wr_en   = 1'b0;
        wr_addr = r_b;
        wr_data = '0;
        unique case (i_op)
            OP_RD_B: begin
                rd_en   = 1'b1;
                rd_addr = free_unit;
            end
            OP_RD_WALK: begin
                rd_en = 1'b1;
            end
            OP_RD_CUR: begin
                rd_en   = 1'b1;
                rd_addr = r_cur[UNIT_W-1:0];
            end
            OP_RD_NXT: begin
                rd_en   = 1'b1;
                rd_addr = r_nxt[UNIT_W-1:0];
            end
            OP_INIT: begin
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data.size    = SIZE_W'(INIT_UNITS);
                wr_data.is_free = 1'b1;
            end
            OP_GROW: begin
                wr_en        = 1'b1;
                wr_addr      = r_top[UNIT_W-1:0];
                wr_data.size = r_need;
            end
            OP_SPLIT: begin
                wr_en              = 1'b1;
                wr_addr            = sp;
                wr_data.size       = r_rd.size - r_need;
                wr_data.next       = r_rd.next;
                wr_data.is_free    = 1'b1;
                wr_data.next_valid = r_rd.next_valid;
            end
            OP_LINK: begin
                wr_en              = r_pv;
                wr_addr            = r_prev;
                wr_data.size       = r_phdr.size;
                wr_data.next       = s_next;
                wr_data.is_free    = r_phdr.is_free;
                wr_data.next_valid = s_nv;
            end
            OP_TAKE: begin
                wr_en        = 1'b1;
                wr_data.size = split ? r_need : r_rd.size;
            end
            OP_MARK: begin
                wr_en           = 1'b1;
                wr_data.size    = r_rd.size;
                wr_data.is_free = 1'b1;
            end
            OP_SCAN_WR: begin
                wr_en              = 1'b1;
                wr_addr            = r_cur[UNIT_W-1:0];
                wr_data.size       = r_c.size;
                wr_data.is_free    = r_c.is_free;
                wr_data.next       = r_c.is_free ? r_fh : '0;
                wr_data.next_valid = r_c.is_free & r_fhv;
            end
            default: begin
            end
        endcase
    end

    // header memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // heap control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_fh    <= '0;
            r_fhv   <= 1'b0;
            r_ready <= 1'b0;
            r_limit <= LIMIT_W'(HEAP_UNITS);
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_limit <= i_limit;
            end
            r_done <= (i_op == OP_RET_ALLOC) || (i_op == OP_RET_ZERO) ||
                      (i_op == OP_RET_OOM) || (i_op == OP_RET_FREED) ||
                      (i_op == OP_RET_NULL);
            unique case (i_op)
                OP_INIT: begin
                    r_fh    <= '0;
                    r_fhv   <= 1'b1;
                    r_top   <= TOP_W'(INIT_UNITS);
                    r_ready <= 1'b1;
                end
                OP_GROW: begin
                    r_top <= TOP_W'(r_top + r_need);
                end
                OP_LINK: begin
                    if (!r_pv) begin
                        r_fh  <= s_next;
                        r_fhv <= s_nv;
                    end
                end
                OP_MARK: begin
                    r_fh  <= '0;
                    r_fhv <= 1'b0;
                end
                OP_SCAN_WR: begin
                    if (r_c.is_free) begin
                        r_fh  <= r_cur[UNIT_W-1:0];
                        r_fhv <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_act        <= i_action;
                r_size_zero  <= (i_size_bytes == '0);
                r_addr_zero  <= (i_address == '0);
                r_addr_units <= i_address[ADDR_W-1:3];
                r_need       <= need_in;
            end
            OP_RD_B: begin
                r_b <= free_unit;
            end
            OP_WALK_BEGIN: begin
                r_b     <= r_fh;
                r_bv    <= r_fhv;
                r_pv    <= 1'b0;
                r_steps <= '0;
            end
            OP_ADVANCE: begin
                r_prev  <= r_b;
                r_pv    <= 1'b1;
                r_phdr  <= r_rd;
                r_bv    <= r_rd.next_valid;
                r_b     <= r_rd.next;
                r_steps <= r_steps + STEPS_W'(1);
            end
            OP_GROW: begin
                r_b <= r_top[UNIT_W-1:0];
            end
            OP_MARK: begin
                r_cur <= '0;
            end
            OP_CAPTURE: begin
                r_c   <= r_rd;
                r_nxt <= r_cur + r_rd.size;
            end
            OP_MERGE: begin
                r_c.size <= merged;
                r_nxt    <= r_cur + merged;
            end
            OP_SCAN_WR: begin
                r_cur <= r_cur + r_c.size;
            end
            OP_RET_ALLOC: begin
                r_ptr    <= {r_b + UNIT_W'(HEADER_UNITS), 3'b000};
                r_status <= ST_ALLOC;
            end
            OP_RET_ZERO: begin
                r_ptr    <= '0;
                r_status <= ST_ZERO;
            end
            OP_RET_OOM: begin
                r_ptr    <= '0;
                r_status <= ST_OOM;
            end
            OP_RET_FREED: begin
                r_ptr    <= '0;
                r_status <= ST_FREED;
            end
            OP_RET_NULL: begin
                r_ptr    <= '0;
                r_status <= ST_NULL;
            end
            default: begin
            end
        endcase
    end

    assign o_pointer_offset = r_ptr;
    assign o_status         = r_status;
    assign o_done           = r_done;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with free-list split and forward coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low; i_action selects
//   allocate or free, with i_size_bytes or i_address as operand.
//   One result per request: o_done is high for one cycle with o_status and
//   o_pointer_offset; the result cannot be held off by the receiver.
//   The limit register is written through i_cfg_valid / o_cfg_ready; the user must
//   write it only while the block is idle, which the block does not enforce; o_cfg_ready is always high.
// Operation:
//   null free, zero size and refused setup return without memory access.
//   allocate walks the free list and takes the first free block that fits
//   (split or not), else grows the top, else reports out of memory;
//   the first allocate also sets up the initial block.
//   free scans the heap from its base, merging each free block with the free
//   blocks that follow it and rebuilding the free list.
//   A new request can be taken in the cycle in which o_done is high.
// Reset:
//   i_rst_n clears the heap top, free list and setup flag and sets the limit
//   to the full heap; header memory is left as is.
module first_fit_heap_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [ffha_pkg::REQ_W-1:0]   i_size_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]  i_address,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ffha_pkg::LIMIT_W-1:0] i_heap_limit_units,
    output logic                         o_done,
    output logic [ffha_pkg::PTR_W-1:0]   o_pointer_offset,
    output logic [2:0]                   o_status
);
    import ffha_pkg::*;

    t_op      op;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy)
    );

    // header memory and registers
    ffha_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_action         (i_action),
        .i_size_bytes     (i_size_bytes),
        .i_address        (i_address),
        .i_cfg_wr         (i_cfg_valid & o_cfg_ready),
        .i_limit          (i_heap_limit_units),
        .o_stat           (stat),
        .o_pointer_offset (o_pointer_offset),
        .o_status         (o_status),
        .o_done           (o_done)
    );

endmodule

// ===== rtl/ffha_chk.sv =====
// ----------------------------------------------------------------------------
// ffha_chk
// Port-level checks on the heap allocator result and busy behaviour.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module ffha_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [ffha_pkg::PTR_W-1:0] o_pointer_offset,
    input logic [2:0]                 o_status
);
    import ffha_pkg::*;

    logic fail_done;
    logic status_known;

    // result classification
    assign fail_done    = o_done && (o_status != ST_ALLOC);
    assign status_known = (o_status == ST_ALLOC) || (o_status == ST_ZERO) ||
                          (o_status == ST_OOM) || (o_status == ST_FREED) ||
                          (o_status == ST_NULL);

    // a taken request keeps the block busy in the next cycle
    `FFHA_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "busy not raised")

    // a result leaves the block ready for the next request
    `FFHA_ASSERT_NOW(a_idle_on_done, i_clk, i_rst_n, o_done, !busy, "busy during result")

    // no two results back to back
    `FFHA_ASSERT_NEXT(a_single_done, i_clk, i_rst_n, o_done, !o_done, "repeated result")

    // only allocations carry a pointer
    `FFHA_ASSERT_NOW(a_null_ptr, i_clk, i_rst_n, fail_done, o_pointer_offset == '0, "bad ptr")

    // status code is one of the defined ones
    `FFHA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_done, status_known, "bad status")

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_pointer_offset (o_pointer_offset),
    .o_status         (o_status)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the first-fit heap allocator against a behavioural copy of its heap:
// allocate and free requests with random gaps, limit changes while idle, and
// every result compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import ffha_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 6000000;

    typedef struct {
        logic                act;
        logic [REQ_W-1:0]    size;
        logic [ADDR_W-1:0]   addr;
    } t_req;

    typedef struct {
        logic [PTR_W-1:0] ptr;
        t_status          st;
    } t_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_action = 1'b0;
    logic [REQ_W-1:0]     i_size_bytes = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_heap_limit_units = '0;
    logic                 o_done;
    logic [PTR_W-1:0]     o_pointer_offset;
    logic [2:0]           o_status;

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_size_bytes(i_size_bytes), .i_address(i_address),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_heap_limit_units(i_heap_limit_units), .o_done(o_done),
        .o_pointer_offset(o_pointer_offset), .o_status(o_status)
    );

    always #4 i_clk = ~i_clk;

    // shadow heap
    int unsigned blk_size [HEAP_UNITS];
    bit [15:0]   blk_next [HEAP_UNITS];
    bit          blk_free [HEAP_UNITS];
    bit          blk_nv   [HEAP_UNITS];
    int unsigned top_units = 0;
    bit [15:0]   list_head = 0;
    bit          list_valid = 0;
    bit          heap_set = 0;
    int unsigned limit_units = 65536;

    t_req        pending [$];
    t_res        awaited [$];
    logic [ADDR_W-1:0] live_ptrs [$];
    logic [ADDR_W-1:0] freed_ptrs [$];
    int          gap_max = 6;
    int          gap_left = 0;
    int          mismatches = 0;
    int unsigned cycles = 0;

    function automatic int unsigned eff_limit();
        return (limit_units > HEAP_UNITS) ? HEAP_UNITS : limit_units;
    endfunction

    // coalesce forward runs then rebuild the free list, descending order
    function automatic void coalesce_and_relink();
        int unsigned cur;
        int unsigned nxt;
        cur = 0;
        while (cur < top_units && blk_size[cur] >= HEADER_UNITS) begin
            if (blk_free[cur]) begin
                nxt = cur + blk_size[cur];
                while (nxt > cur && nxt < top_units && blk_size[nxt] >= HEADER_UNITS
                       && blk_free[nxt]) begin
                    blk_size[cur] += blk_size[nxt];
                    nxt = cur + blk_size[cur];
                end
            end
            cur += blk_size[cur];
        end
        list_head = 0;
        list_valid = 0;
        cur = 0;
        while (cur < top_units && blk_size[cur] >= HEADER_UNITS) begin
            if (blk_free[cur]) begin
                blk_next[cur] = list_head;
                blk_nv[cur] = list_valid;
                list_head = cur[15:0];
                list_valid = 1;
            end else begin
                blk_next[cur] = 0;
                blk_nv[cur] = 0;
            end
            cur += blk_size[cur];
        end
    endfunction

    function automatic t_res heap_step(t_req r);
        t_res        res;
        bit [15:0]   b;
        bit [15:0]   prv;
        bit [15:0]   sp;
        bit          bv;
        bit          pv;
        int unsigned need;
        int unsigned steps;
        res.ptr = '0;
        if (r.act) begin
            if (r.addr == 0) begin
                res.st = ST_NULL;
                return res;
            end
            b = 16'((r.addr >> 3) + HEAP_UNITS - HEADER_UNITS);
            blk_free[b] = 1;
            blk_next[b] = 0;
            blk_nv[b] = 0;
            coalesce_and_relink();
            res.st = ST_FREED;
            return res;
        end
        if (r.size == 0) begin
            res.st = ST_ZERO;
            return res;
        end
        if (!heap_set && INIT_UNITS <= eff_limit()) begin
            blk_size[0] = INIT_UNITS;
            blk_free[0] = 1;
            blk_next[0] = 0;
            blk_nv[0] = 0;
            list_head = 0;
            list_valid = 1;
            top_units = INIT_UNITS;
            heap_set = 1;
        end
        if (!heap_set) begin
            res.st = ST_OOM;
            return res;
        end
        need = ((r.size + 7) >> 3) + HEADER_UNITS;
        b = list_head;
        bv = list_valid;
        prv = 0;
        pv = 0;
        steps = 0;
        // first-fit walk of the free list
        while (bv && steps < HEAP_UNITS) begin
            if (blk_free[b] && blk_size[b] >= need) begin
                if (blk_size[b] >= need + HEADER_UNITS + SPLIT_SPARE) begin
                    sp = 16'(b + need);
                    blk_size[sp] = blk_size[b] - need;
                    blk_free[sp] = 1;
                    blk_next[sp] = blk_next[b];
                    blk_nv[sp] = blk_nv[b];
                    blk_size[b] = need;
                    blk_next[b] = sp;
                    blk_nv[b] = 1;
                end
                blk_free[b] = 0;
                if (pv) begin
                    blk_next[prv] = blk_next[b];
                    blk_nv[prv] = blk_nv[b];
                end else begin
                    list_head = blk_next[b];
                    list_valid = blk_nv[b];
                end
                blk_next[b] = 0;
                blk_nv[b] = 0;
                res.ptr = PTR_W'((b + HEADER_UNITS) * 8);
                res.st = ST_ALLOC;
                return res;
            end
            prv = b;
            pv = 1;
            bv = blk_nv[b];
            b = blk_next[b];
            steps++;
        end
        // grow the top
        if (top_units + need > eff_limit()) begin
            res.st = ST_OOM;
            return res;
        end
        b = 16'(top_units);
        blk_size[b] = need;
        blk_free[b] = 0;
        blk_next[b] = 0;
        blk_nv[b] = 0;
        top_units += need;
        res.ptr = PTR_W'((top_units - need + HEADER_UNITS) * 8);
        res.st = ST_ALLOC;
        return res;
    endfunction

    // driver: one transaction per accepted start
    always @(posedge i_clk) begin
        t_res r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                r = heap_step(pending[0]);
                awaited.push_back(r);
                if (r.st == ST_ALLOC) live_ptrs.push_back(r.ptr);
                void'(pending.pop_front());
                gap_left = $urandom_range(0, gap_max);
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending.size() > 0) begin
                    start <= 1'b1;
                    i_action <= pending[0].act;
                    i_size_bytes <= pending[0].size;
                    i_address <= pending[0].addr;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else if (i_rst_n && o_done) begin
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result ptr=%h status=%0d",
                             o_pointer_offset, o_status);
            end else begin
                e = awaited.pop_front();
                if (o_pointer_offset !== e.ptr || o_status !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ptr=%h status=%0d, got ptr=%h status=%0d",
                                 e.ptr, e.st, o_pointer_offset, o_status);
                end
            end
        end
    end

    task automatic push_req(logic act, logic [REQ_W-1:0] sz, logic [ADDR_W-1:0] ad);
        t_req q;
        q.act = act;
        q.size = sz;
        q.addr = ad;
        pending.push_back(q);
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || awaited.size() > 0 || start) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(int unsigned v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_heap_limit_units <= LIMIT_W'(v);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_units = v;
        i_cfg_valid <= 1'b0;
    endtask

    // one random transaction, mostly well-formed alloc/free traffic
    task automatic push_random();
        int unsigned pick;
        int unsigned idx;
        logic [ADDR_W-1:0] p;
        pick = $urandom_range(0, 99);
        while (pending.size() > 1) @(posedge i_clk);
        if (pick < 5) begin
            push_req(1'b1, REQ_W'($urandom), '0);
        end else if (pick < 8 && freed_ptrs.size() > 0) begin
            // double free of an old block
            p = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
            push_req(1'b1, REQ_W'($urandom), p | ADDR_W'($urandom_range(0, 7)));
        end else if (live_ptrs.size() > 0 && (pick < 45 || live_ptrs.size() > 30)) begin
            idx = $urandom_range(0, live_ptrs.size() - 1);
            p = live_ptrs[idx];
            live_ptrs.delete(idx);
            freed_ptrs.push_back(p);
            push_req(1'b1, REQ_W'($urandom), p | ADDR_W'($urandom_range(0, 7)));
        end else if (pick < 48) begin
            push_req(1'b0, '0, ADDR_W'($urandom));
        end else if (pick < 51) begin
            push_req(1'b0, REQ_W'($urandom), ADDR_W'($urandom));
        end else if (pick < 55) begin
            push_req(1'b0, REQ_W'($urandom_range(4096, 524288)), ADDR_W'($urandom));
        end else if (pick < 75) begin
            push_req(1'b0, REQ_W'($urandom_range(1, 4096)), ADDR_W'($urandom));
        end else begin
            push_req(1'b0, REQ_W'($urandom_range(1, 200)), ADDR_W'($urandom));
        end
    endtask

    task automatic p_free_first();
        logic [ADDR_W-1:0] p;
        p = live_ptrs.pop_front();
        freed_ptrs.push_back(p);
        push_req(1'b1, '0, p | ADDR_W'(7));
    endtask

    initial begin
        int unsigned lim;
        int unsigned k;
        foreach (blk_size[i]) begin
            blk_size[i] = 0;
            blk_next[i] = 0;
            blk_free[i] = 0;
            blk_nv[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: refused setup, zero size, null free, then tight limit
        gap_max = 0;
        write_limit(1);
        push_req(1'b0, 20'd8, '0);
        push_req(1'b0, '0, '0);
        push_req(1'b1, '0, '0);
        write_limit(512);
        push_req(1'b0, 20'd1, '0);
        push_req(1'b0, 20'd4000, '0);
        push_req(1'b0, 20'd8, '0);
        push_req(1'b0, 20'd524288, '0);
        push_req(1'b0, 20'hFFFFF, '0);
        wait_idle();
        // odd address frees of the blocks just taken
        while (live_ptrs.size() > 0) begin
            p_free_first();
        end
        write_limit(65536);
        push_req(1'b0, 20'd400000, '0);
        push_req(1'b0, 20'd24, '0);
        push_req(1'b0, 20'd100000, '0);
        push_req(1'b0, 20'd1, '0);
        push_req(1'b0, 20'd524288, '0);
        wait_idle();
        while (live_ptrs.size() > 0) begin
            p_free_first();
        end

        // random phases at several limits
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: lim = 65536;
                1: lim = top_units + $urandom_range(0, 64);
                2: lim = 65536;
                3: lim = $urandom_range(1, 65536);
                default: lim = $urandom_range(top_units, 65536);
            endcase
            write_limit(lim);
            gap_max = (ph == 2) ? 0 : 6;
            for (k = 0; k < 80; k++) push_random();
        end
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && awaited.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_chk.sv
tb/tb.sv
